// File: rtl/single_wire_sensor_frame_reader_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the single-wire sensor frame reader
// Short forms for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_SENSOR_FRAME_READER_MACROS_SVH
`define SINGLE_WIRE_SENSOR_FRAME_READER_MACROS_SVH

// antecedent implies consequent on the same clock edge
`define SWSFR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent on the next clock edge
`define SWSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/swsfr_pkg.sv
// ----------------------------------------------------------------------------
// swsfr_pkg
// Types and constants shared by the sensor frame reader modules.
// ----------------------------------------------------------------------------
package swsfr_pkg;

	localparam int FRAME_BITS  = 40;
	localparam int COUNT_WIDTH = 16;
	localparam int BITS_W      = $clog2(FRAME_BITS + 1);
	localparam int CMP_W       = COUNT_WIDTH + 16;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [6:0]             TEMP_MAX = 7'd99;

	localparam logic [15:0] START_LOW_RST = 16'd18000;
	localparam logic [7:0]  RELEASE_RST   = 8'd30;
	localparam logic [7:0]  TIMEOUT_RST   = 8'd120;
	localparam logic [7:0]  THRESH_RST    = 8'd50;
	localparam logic [6:0]  OFFSET_RST    = 7'd0;

	typedef enum logic [2:0] {
		REG_START_LOW = 3'd0,
		REG_RELEASE   = 3'd1,
		REG_TIMEOUT   = 3'd2,
		REG_THRESHOLD = 3'd3,
		REG_OFFSET    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_HOST_LOW  = 3'd1,
		PH_HOST_HIGH = 3'd2,
		PH_ACK_LOW   = 3'd3,
		PH_ACK_HIGH  = 3'd4,
		PH_ACK_END   = 3'd5,
		PH_BIT_HIGH  = 3'd6,
		PH_BIT_MEAS  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TIMEOUT  = 2'd1,
		ST_CHECKSUM = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0]       start_low_ticks;
		logic [7:0]        release_ticks;
		logic [7:0]        timeout_ticks;
		logic [7:0]        one_threshold_ticks;
		logic signed [6:0] temp_offset;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       drive_high;
		logic       busy_res;
		logic       done_res;
		status_t    status;
		logic [7:0] humidity_int;
		logic [7:0] humidity_frac;
		logic [7:0] temperature_int;
		logic [7:0] temperature_frac;
		logic [6:0] temperature_reported;
	} res_t;

endpackage

// File: rtl/single_wire_sensor_frame_reader.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_reader
// Reads one frame from a single-wire humidity/temperature sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transfer on in_valid/in_ready is one microsecond tick carrying
//   start_req and the sampled line_level. Every tick gives exactly one result
//   transfer on out_valid/out_ready: the line drive controls, busy, done with
//   status, the received bytes and the offset temperature clamped to 0..99.
//   A start request is honored only while no read is in progress.
//   A tick accepted into the input register is processed and written to the
//   result register once that register is free or being drained, then offered.
//   Throughput: one tick per cycle while out_ready stays high, set by the
//   single state update from the input register to the result register.
//   Settings must be written on the APB-style port only while no tick is in
//   flight; the block itself does not enforce this.
//   Reset: the settings return to their defaults, the reader goes idle with
//   an empty frame, and both registers are emptied.
//   Stall: when out_ready is low the result register holds, then the input
//   register fills and in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "single_wire_sensor_frame_reader_macros.svh"

module single_wire_sensor_frame_reader import swsfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              start_req,
	input  logic              line_level,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              drive_low,
	output logic              drive_high,
	output logic              busy_res,
	output logic              done_res,
	output logic [1:0]        status,
	output logic [7:0]        humidity_int,
	output logic [7:0]        humidity_frac,
	output logic [7:0]        temperature_int,
	output logic [7:0]        temperature_frac,
	output logic [6:0]        temperature_reported
);

	cfg_t cfg;
	res_t res_d, res_q;
	logic valid_s1, start_s1, level_s1;
	logic out_valid_q;
	logic advance;

	swsfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swsfr_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.start_req  (start_s1),
		.line_level (level_s1),
		.cfg        (cfg),
		.res        (res_d)
	);

	// process the held tick when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			start_s1 <= start_req;
			level_s1 <= line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid            = out_valid_q;
	assign drive_low            = res_q.drive_low;
	assign drive_high           = res_q.drive_high;
	assign busy_res             = res_q.busy_res;
	assign done_res             = res_q.done_res;
	assign status               = res_q.status;
	assign humidity_int         = res_q.humidity_int;
	assign humidity_frac        = res_q.humidity_frac;
	assign temperature_int      = res_q.temperature_int;
	assign temperature_frac     = res_q.temperature_frac;
	assign temperature_reported = res_q.temperature_reported;

	`SWSFR_ASSERT_SAME(a_done_in_txn, out_valid && done_res, busy_res, "done outside a read")
	`SWSFR_ASSERT_SAME(a_drive_excl, out_valid, !(drive_low && drive_high), "line driven both ways")
	`SWSFR_ASSERT_SAME(a_status_done, out_valid && (status != ST_OK), done_res, "status without done")
	`SWSFR_ASSERT_SAME(a_temp_range, out_valid, temperature_reported <= TEMP_MAX, "temperature out of range")
	`SWSFR_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1, "held tick lost")

endmodule

// File: rtl/swsfr_cfg.sv
// ----------------------------------------------------------------------------
// swsfr_cfg
// APB-style register file holding the timing and offset settings.
// ----------------------------------------------------------------------------
module swsfr_cfg import swsfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks     <= START_LOW_RST;
			cfg_q.release_ticks       <= RELEASE_RST;
			cfg_q.timeout_ticks       <= TIMEOUT_RST;
			cfg_q.one_threshold_ticks <= THRESH_RST;
			cfg_q.temp_offset         <= OFFSET_RST;
		end else if (wr_en) begin
			case (idx)
				REG_START_LOW: cfg_q.start_low_ticks     <= pwdata[15:0];
				REG_RELEASE:   cfg_q.release_ticks       <= pwdata[7:0];
				REG_TIMEOUT:   cfg_q.timeout_ticks       <= pwdata[7:0];
				REG_THRESHOLD: cfg_q.one_threshold_ticks <= pwdata[7:0];
				REG_OFFSET:    cfg_q.temp_offset         <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_START_LOW: prdata = {16'd0, cfg_q.start_low_ticks};
			REG_RELEASE:   prdata = {24'd0, cfg_q.release_ticks};
			REG_TIMEOUT:   prdata = {24'd0, cfg_q.timeout_ticks};
			REG_THRESHOLD: prdata = {24'd0, cfg_q.one_threshold_ticks};
			REG_OFFSET:    prdata = {25'd0, cfg_q.temp_offset};
			default:       prdata = '0;
		endcase
	end

endmodule

// File: rtl/swsfr_engine.sv
// ----------------------------------------------------------------------------
// swsfr_engine
// Transaction state machine, bit timer, frame shifter and result forming.
// ----------------------------------------------------------------------------
module swsfr_engine import swsfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic start_req,
	input  logic line_level,
	input  cfg_t cfg,
	output res_t res
);

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
	logic [BITS_W-1:0]      bits_q, bits_d, bits_inc;
	logic [FRAME_BITS-1:0]  frame_q, frame_d;
	logic                   done;
	status_t                status;
	logic                   want;
	logic                   bit_val;
	logic [7:0]             sum;
	logic signed [9:0]      temp_sum;
	logic [6:0]             temp_clamped;

	assign cnt_inc  = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign bits_inc = bits_q + 1'b1;
	assign want     = (phase_q == PH_ACK_HIGH) || (phase_q == PH_BIT_HIGH);
	assign bit_val  = CMP_W'(cnt_inc) > CMP_W'(cfg.one_threshold_ticks);
	assign sum      = frame_d[39:32] + frame_d[31:24] + frame_d[23:16] + frame_d[15:8];

	// next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		bits_d  = bits_q;
		frame_d = frame_q;
		done    = 1'b0;
		status  = ST_OK;
		case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_d = PH_HOST_LOW;
					cnt_d   = '0;
					bits_d  = '0;
					frame_d = '0;
				end
			end
			PH_HOST_LOW: begin
				cnt_d = cnt_inc;
				if (CMP_W'(cnt_inc) >= CMP_W'(cfg.start_low_ticks) || cnt_inc == CNT_MAX) begin
					cnt_d   = '0;
					phase_d = (cfg.release_ticks == 8'd0) ? PH_ACK_LOW : PH_HOST_HIGH;
				end
			end
			PH_HOST_HIGH: begin
				cnt_d = cnt_inc;
				if (CMP_W'(cnt_inc) >= CMP_W'(cfg.release_ticks)) begin
					cnt_d   = '0;
					phase_d = PH_ACK_LOW;
				end
			end
			default: begin
				cnt_d = cnt_inc;
				if (line_level == want) begin
					cnt_d = '0;
					case (phase_q)
						PH_ACK_LOW:  phase_d = PH_ACK_HIGH;
						PH_ACK_HIGH: phase_d = PH_ACK_END;
						PH_ACK_END:  phase_d = PH_BIT_HIGH;
						PH_BIT_HIGH: phase_d = PH_BIT_MEAS;
						default: begin
							frame_d = {frame_q[FRAME_BITS-2:0], bit_val};
							bits_d  = bits_inc;
							if (bits_inc >= BITS_W'(FRAME_BITS)) begin
								done    = 1'b1;
								status  = (sum == frame_d[7:0]) ? ST_OK : ST_CHECKSUM;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_BIT_HIGH;
							end
						end
					endcase
				end else if (CMP_W'(cnt_inc) > CMP_W'(cfg.timeout_ticks)) begin
					done    = 1'b1;
					status  = ST_TIMEOUT;
					cnt_d   = '0;
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	// temperature with offset, saturated to the reporting range
	always_comb begin
		temp_sum = $signed({2'b00, frame_d[23:16]}) + 10'(cfg.temp_offset);
		if (temp_sum < 10'sd0) begin
			temp_clamped = 7'd0;
		end else if (temp_sum > $signed({3'b000, TEMP_MAX})) begin
			temp_clamped = TEMP_MAX;
		end else begin
			temp_clamped = temp_sum[6:0];
		end
	end

	// outputs
	always_comb begin
		res.drive_low            = (phase_q == PH_HOST_LOW);
		res.drive_high           = (phase_q == PH_HOST_HIGH);
		res.busy_res             = (phase_q != PH_IDLE);
		res.done_res             = done;
		res.status               = status;
		res.humidity_int         = frame_d[39:32];
		res.humidity_frac        = frame_d[31:24];
		res.temperature_int      = frame_d[23:16];
		res.temperature_frac     = frame_d[15:8];
		res.temperature_reported = temp_clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			bits_q  <= '0;
			frame_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			bits_q  <= bits_d;
			frame_q <= frame_d;
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: frame reader testbench
// Sends microsecond ticks that act out the sensor's side of the single-wire
// exchange, predicts every per-tick result in a behavioral copy of the
// reader, and compares each result transfer field by field. Directed tests
// hit register extremes, byte and temperature clamp corners, host timing,
// and timeouts at every kind of wait. Random frames follow.
// ----------------------------------------------------------------------------
module tb_top;
	import swsfr_pkg::*;

	localparam int FRAME_WAITS = 3 + 2 * FRAME_BITS;
	localparam int NO_CUT      = -1;

	logic              clk;
	logic              arst_n     = 1'b0;
	logic              psel       = 1'b0;
	logic              penable    = 1'b0;
	logic              pwrite     = 1'b0;
	logic [ADDR_W-1:0] paddr      = '0;
	logic [DATA_W-1:0] pwdata     = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic              start_req  = 1'b0;
	logic              line_level = 1'b0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic              drive_low;
	logic              drive_high;
	logic              busy_res;
	logic              done_res;
	logic [1:0]        status;
	logic [7:0]        humidity_int;
	logic [7:0]        humidity_frac;
	logic [7:0]        temperature_int;
	logic [7:0]        temperature_frac;
	logic [6:0]        temperature_reported;

	single_wire_sensor_frame_reader dut (.*);

	// reader state as the testbench sees it
	cfg_t        reader_cfg = '{START_LOW_RST, RELEASE_RST, TIMEOUT_RST, THRESH_RST, OFFSET_RST};
	phase_t      rd_phase   = PH_IDLE;
	int unsigned rd_count   = 0;
	int          rd_bits    = 0;
	logic [39:0] rd_frame   = '0;

	res_t tick_results_due[$];
	int   fail_count     = 0;
	int   ticks_sent     = 0;
	int   reg_writes     = 0;
	int   frames_ok      = 0;
	int   frames_timeout = 0;
	int   frames_bad_sum = 0;
	bit   idle_en        = 1'b1;
	int   stall_left     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [39:0] make_frame(logic [7:0] h_i, logic [7:0] h_f,
			logic [7:0] t_i, logic [7:0] t_f);
		logic [7:0] sum;
		sum = h_i + h_f + t_i + t_f;
		return {h_i, h_f, t_i, t_f, sum};
	endfunction

	function automatic logic [39:0] random_frame();
		return make_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endfunction

	// advance the reader copy by one tick and return what it shows on that tick
	function automatic res_t reader_step(logic start, logic level);
		res_t r;
		logic want;
		logic [7:0] sum;
		int t;
		r = '0;
		r.status = ST_OK;
		r.busy_res = (rd_phase != PH_IDLE);
		case (rd_phase)
			PH_IDLE: begin
				if (start) begin
					rd_phase = PH_HOST_LOW;
					rd_count = 0;
					rd_bits = 0;
					rd_frame = '0;
				end
			end
			PH_HOST_LOW: begin
				r.drive_low = 1'b1;
				if (rd_count < CNT_MAX) rd_count++;
				if (rd_count >= reader_cfg.start_low_ticks || rd_count >= CNT_MAX) begin
					rd_count = 0;
					rd_phase = (reader_cfg.release_ticks == 0) ? PH_ACK_LOW : PH_HOST_HIGH;
				end
			end
			PH_HOST_HIGH: begin
				r.drive_high = 1'b1;
				if (rd_count < CNT_MAX) rd_count++;
				if (rd_count >= reader_cfg.release_ticks) begin
					rd_count = 0;
					rd_phase = PH_ACK_LOW;
				end
			end
			default: begin
				want = (rd_phase == PH_ACK_HIGH || rd_phase == PH_BIT_HIGH);
				if (rd_count < CNT_MAX) rd_count++;
				if (level == want) begin
					if (rd_phase == PH_BIT_MEAS) begin
						rd_frame = {rd_frame[38:0], rd_count > reader_cfg.one_threshold_ticks};
						rd_bits++;
						rd_count = 0;
						if (rd_bits >= FRAME_BITS) begin
							sum = rd_frame[39:32] + rd_frame[31:24] + rd_frame[23:16]
								+ rd_frame[15:8];
							r.done_res = 1'b1;
							r.status = (sum == rd_frame[7:0]) ? ST_OK : ST_CHECKSUM;
							rd_phase = PH_IDLE;
						end else begin
							rd_phase = PH_BIT_HIGH;
						end
					end else begin
						rd_count = 0;
						rd_phase = (rd_phase == PH_ACK_END) ? PH_BIT_HIGH
							: phase_t'(rd_phase + 1);
					end
				end else if (rd_count > reader_cfg.timeout_ticks) begin
					r.done_res = 1'b1;
					r.status = ST_TIMEOUT;
					rd_count = 0;
					rd_phase = PH_IDLE;
				end
			end
		endcase
		if (r.done_res) begin
			case (r.status)
				ST_OK:      frames_ok++;
				ST_TIMEOUT: frames_timeout++;
				default:    frames_bad_sum++;
			endcase
		end
		r.humidity_int     = rd_frame[39:32];
		r.humidity_frac    = rd_frame[31:24];
		r.temperature_int  = rd_frame[23:16];
		r.temperature_frac = rd_frame[15:8];
		t = int'(rd_frame[23:16]) + int'($signed(reader_cfg.temp_offset));
		if (t < 0) t = 0;
		if (t > int'(TEMP_MAX)) t = int'(TEMP_MAX);
		r.temperature_reported = 7'(t);
		return r;
	endfunction

	// one tick transfer; valid stays high afterwards unless the next call idles
	task automatic send_tick(input logic start, input logic level);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		start_req  <= start;
		line_level <= level;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tick_results_due.push_back(reader_step(start, level));
		ticks_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tick_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(idx));
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_START_LOW: reader_cfg.start_low_ticks     = val[15:0];
			REG_RELEASE:   reader_cfg.release_ticks       = val[7:0];
			REG_TIMEOUT:   reader_cfg.timeout_ticks       = val[7:0];
			REG_THRESHOLD: reader_cfg.one_threshold_ticks = val[7:0];
			default:       reader_cfg.temp_offset         = val[6:0];
		endcase
		reg_writes++;
	endtask

	task automatic check_readback(input reg_idx_t idx);
		logic [31:0] got_v;
		logic [31:0] want_v;
		logic [31:0] mask;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'(4 * int'(idx));
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got_v = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_START_LOW: begin want_v = 32'(reader_cfg.start_low_ticks);     mask = 32'hFFFF; end
			REG_RELEASE:   begin want_v = 32'(reader_cfg.release_ticks);       mask = 32'hFF;   end
			REG_TIMEOUT:   begin want_v = 32'(reader_cfg.timeout_ticks);       mask = 32'hFF;   end
			REG_THRESHOLD: begin want_v = 32'(reader_cfg.one_threshold_ticks); mask = 32'hFF;   end
			default:       begin want_v = 32'(unsigned'(reader_cfg.temp_offset)); mask = 32'h7F; end
		endcase
		if ((got_v & mask) !== (want_v & mask)) begin
			$error("register %s: expected %0d, got %0d", idx.name(), want_v & mask, got_v & mask);
			fail_count++;
		end
	endtask

	task automatic set_cfg(input int sl, input int rl, input int to, input int th, input int off);
		drain();
		write_reg(REG_START_LOW, 32'(sl) & 32'hFFFF);
		write_reg(REG_RELEASE,   32'(rl) & 32'hFF);
		write_reg(REG_TIMEOUT,   32'(to) & 32'hFF);
		write_reg(REG_THRESHOLD, 32'(th) & 32'hFF);
		write_reg(REG_OFFSET,    32'(off) & 32'h7F);
	endtask

	// play the sensor side of one exchange; cut aborts by timeout at that wait
	task automatic run_frame(input logic [39:0] data, input int cut, input int max_lead,
			input bit tight);
		int to, th, lead, lo, hi, w, b;
		logic want;
		logic bitv;
		to = int'(reader_cfg.timeout_ticks);
		th = int'(reader_cfg.one_threshold_ticks);
		send_tick(1'b1, coin());
		while (rd_phase == PH_HOST_LOW || rd_phase == PH_HOST_HIGH)
			send_tick(coin(), coin());
		for (int i = 0; i < FRAME_WAITS; i++) begin
			want = (i < 3) ? (i == 1) : (((i - 3) % 2) == 0);
			if (i == cut) begin
				repeat (to + 1) send_tick(coin(), !want);
				return;
			end
			if (i >= 3 && !want) begin
				b = (i - 4) / 2;
				bitv = data[FRAME_BITS-1-b];
				lo = bitv ? th + 1 : 1;
				hi = bitv ? to + 1 : th;
				if (hi > to + 1) hi = to + 1;
				if (hi < 1) hi = 1;
				if (lo > hi) lo = hi;
				if (tight) w = (bitv && coin()) ? lo : hi;
				else w = $urandom_range(lo, hi);
				lead = w - 1;
			end else begin
				lead = tight ? to : $urandom_range(0, (max_lead < to) ? max_lead : to);
			end
			repeat (lead) send_tick(coin(), !want);
			send_tick(coin(), want);
		end
	endtask

	// hold the line low until the reader gives up or finishes
	task automatic finish_txn();
		while (rd_phase != PH_IDLE) send_tick(1'b0, 1'b0);
	endtask

	task automatic line_noise(input int n);
		repeat (n) send_tick($urandom_range(0, 7) == 0, coin());
		finish_txn();
	endtask

	// ------------------------------------------------------------------
	// result checker and receiver stalls
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tick_results_due.size() == 0) begin
				$error("result transfer with no tick outstanding");
				fail_count++;
			end else begin
				want = tick_results_due.pop_front();
				check_field("drive_low", 32'(want.drive_low), 32'(drive_low));
				check_field("drive_high", 32'(want.drive_high), 32'(drive_high));
				check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
				check_field("done_res", 32'(want.done_res), 32'(done_res));
				check_field("status", 32'(want.status), 32'(status));
				check_field("humidity_int", 32'(want.humidity_int), 32'(humidity_int));
				check_field("humidity_frac", 32'(want.humidity_frac), 32'(humidity_frac));
				check_field("temperature_int", 32'(want.temperature_int),
					32'(temperature_int));
				check_field("temperature_frac", 32'(want.temperature_frac),
					32'(temperature_frac));
				check_field("temperature_reported", 32'(want.temperature_reported),
					32'(temperature_reported));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_reset_defaults();
		for (int i = 0; i < 5; i++) check_readback(reg_idx_t'(i));
		// shorten the host low time, keep the rest, and time out at the first bit
		write_reg(REG_START_LOW, 32'd20);
		run_frame(random_frame(), 3, 3, 1'b0);
	endtask

	task automatic test_register_access();
		drain();
		write_reg(REG_START_LOW, 32'hFFFF);  check_readback(REG_START_LOW);
		write_reg(REG_START_LOW, 32'h0);     check_readback(REG_START_LOW);
		write_reg(REG_RELEASE, 32'hFF);      check_readback(REG_RELEASE);
		write_reg(REG_RELEASE, 32'h0);       check_readback(REG_RELEASE);
		write_reg(REG_TIMEOUT, 32'hFF);      check_readback(REG_TIMEOUT);
		write_reg(REG_TIMEOUT, 32'h0);       check_readback(REG_TIMEOUT);
		write_reg(REG_THRESHOLD, 32'hFF);    check_readback(REG_THRESHOLD);
		write_reg(REG_THRESHOLD, 32'h0);     check_readback(REG_THRESHOLD);
		write_reg(REG_OFFSET, 32'h40);       check_readback(REG_OFFSET);
		write_reg(REG_OFFSET, 32'h3F);       check_readback(REG_OFFSET);
	endtask

	task automatic test_byte_extremes();
		set_cfg(1, 1, 6, 3, 0);
		run_frame(40'h0, NO_CUT, 2, 1'b0);
		run_frame(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF), NO_CUT, 2, 1'b1);
		run_frame({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFD}, NO_CUT, 2, 1'b0);
		run_frame(make_frame(8'hAA, 8'h55, 8'hAA, 8'h55), NO_CUT, 2, 1'b1);
	endtask

	task automatic test_temperature_clamp();
		int offs [10] = '{50, 50, 50, -50, -50, -50, 63, -64, -64, -64};
		int temps[10] = '{255, 49, 50, 10, 50, 51, 36, 63, 64, 163};
		for (int i = 0; i < 10; i++) begin
			set_cfg(1, 1, 5, 2, offs[i]);
			run_frame(make_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'(temps[i]), 8'($urandom_range(0, 255))), NO_CUT, 1, 1'b0);
		end
	endtask

	task automatic test_host_timing();
		set_cfg(0, 0, 4, 2, 0);
		run_frame(random_frame(), NO_CUT, 2, 1'b0);
		// next start lands right after the done tick
		run_frame(random_frame(), NO_CUT, 2, 1'b0);
		set_cfg(0, 255, 4, 2, 0);
		run_frame(random_frame(), NO_CUT, 2, 1'b0);
		set_cfg(300, 1, 4, 2, 0);
		run_frame(random_frame(), NO_CUT, 2, 1'b0);
	endtask

	task automatic test_timeouts();
		int cuts[8] = '{0, 1, 2, 3, 4, 5, 44, FRAME_WAITS - 1};
		set_cfg(1, 2, 3, 2, 0);
		foreach (cuts[i]) run_frame(random_frame(), cuts[i], 3, 1'b0);
		run_frame(random_frame(), NO_CUT, 3, 1'b1);
		// zero timeout: any non-matching tick aborts
		set_cfg(1, 0, 0, 1, 0);
		run_frame(40'h0, NO_CUT, 0, 1'b0);
		run_frame(40'h0, 0, 0, 1'b0);
		run_frame(40'h0, 7, 0, 1'b0);
		set_cfg(2, 1, 255, 128, 0);
		run_frame(random_frame(), 9, 0, 1'b0);
		run_frame(random_frame(), 10, 0, 1'b0);
	endtask

	task automatic random_setup();
		int to, th, sl;
		to = $urandom_range(0, 10);
		if ($urandom_range(0, 9) == 0) th = $urandom_range(0, 15);
		else th = $urandom_range(1, (to < 1) ? 1 : to);
		sl = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 200) : $urandom_range(0, 4);
		set_cfg(sl, $urandom_range(0, 3), to, th, $urandom_range(0, 127));
	endtask

	task automatic test_random_frames(input int target, input bit allow_idle);
		int first, pick;
		logic [39:0] f;
		first = ticks_sent;
		random_setup();
		while (ticks_sent - first < target) begin
			if ($urandom_range(0, 1) == 0) random_setup();
			idle_en = allow_idle && ($urandom_range(0, 9) < 7);
			pick = $urandom_range(0, 19);
			f = random_frame();
			if (pick == 14 || pick == 15) f[7:0] = f[7:0] + 8'($urandom_range(1, 255));
			if (pick < 16) run_frame(f, NO_CUT, 2, 1'b0);
			else if (pick < 18) run_frame(f, $urandom_range(0, FRAME_WAITS - 1), 2, 1'b0);
			else line_noise($urandom_range(5, 120));
		end
	endtask

	initial begin
		int waited;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_access();
		test_byte_extremes();
		test_temperature_clamp();
		test_host_timing();
		test_timeouts();
		test_random_frames(1000, 1'b1);
		drain();
		idle_en = 1'b0;
		test_random_frames(250, 1'b0);
		in_valid <= 1'b0;
		waited = 0;
		while (tick_results_due.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (tick_results_due.size() != 0) begin
			$error("%0d tick results never arrived", tick_results_due.size());
			fail_count++;
		end
		$display("Covered %0d ticks and %0d register writes across several settings.",
			ticks_sent, reg_writes);
		$display("Frames ended: %0d clean, %0d timed out, %0d with bad checksum.",
			frames_ok, frames_timeout, frames_bad_sum);
		if (fail_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/swsfr_pkg.sv
rtl/swsfr_cfg.sv
rtl/swsfr_engine.sv
rtl/single_wire_sensor_frame_reader.sv
tb/tb_top.sv
